// ----- rtl/btlpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary trie prefix lookup package
// Shared item kinds, controller states, command and status structs and
// the address space constants used by the lookup core.
// ----------------------------------------------------------------------------
package btlpm_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_FINISH    = 2'd1,
    KIND_LOOKUP_V4 = 2'd2,
    KIND_LOOKUP_V6 = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_node;
    logic start;
    logic step;
    logic load_out;
    logic save_root;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic term;
    logic at_limit;
    logic finish;
  } dp_status_t;

  // Child word layout.
  localparam int unsigned TERM_POS = 31;

  // Walk limits and mask offsets, in address bits.
  localparam logic [7:0] V4_BITS         = 8'd32;
  localparam logic [7:0] V6_BITS         = 8'd128;
  localparam logic [7:0] FINISH_DEPTH    = 8'd96;
  localparam logic [7:0] V4_EMBED_OFFSET = 8'd96;
  localparam logic [7:0] SIXTOFOUR_OFFSET = 8'd16;

  // IPv4-like address space markers.
  localparam logic [31:0] V4_MAPPED_TOP  = 32'h0000_FFFF;
  localparam logic [31:0] SIIT_TOP       = 32'hFFFF_0000;
  localparam logic [31:0] TEREDO_PREFIX  = 32'h2001_0000;
  localparam logic [15:0] SIXTOFOUR_PREFIX = 16'h2002;

endpackage

// ----- rtl/btlpm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered read data. The read
// data holds its value in cycles without a read.
// ----------------------------------------------------------------------------
module btlpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/btlpm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary trie lookup controller
// Accepts items, sequences the trie walk one node per cycle and hands
// finished results to the output register.
// ----------------------------------------------------------------------------
module btlpm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_kind,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output btlpm_pkg::dp_cmd_t     cmd,
  input  btlpm_pkg::dp_status_t  status
);

  btlpm_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_busy;
  logic              is_write;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btlpm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The output register is busy when it holds an item that is not taken now.
  assign out_busy = out_valid_r && out_stall;
  assign is_write = (btlpm_pkg::kind_t'(in_kind) == btlpm_pkg::KIND_WRITE);

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      btlpm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (is_write) begin
            cmd.write_node = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = btlpm_pkg::ST_WALK;
          end
        end
      end
      btlpm_pkg::ST_WALK: begin
        if (status.term || status.at_limit) begin
          if (status.finish) begin
            cmd.save_root = 1'b1;
            state_nxt     = btlpm_pkg::ST_IDLE;
          end else if (status.term) begin
            // Hold the walk until the output register can take the result.
            if (!out_busy) begin
              cmd.load_out  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = btlpm_pkg::ST_IDLE;
            end
          end else begin
            state_nxt = btlpm_pkg::ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = btlpm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/btlpm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary trie lookup datapath
// Classifies the address, holds the current child word, bit count and
// address shift register, reads the node memory and keeps the result.
// ----------------------------------------------------------------------------
module btlpm_dp #(
  parameter int NODE_COUNT = 16384
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  btlpm_pkg::dp_cmd_t     cmd,
  output btlpm_pkg::dp_status_t  status,
  input  logic [1:0]             in_kind,
  input  logic [13:0]            in_node_index,
  input  logic [31:0]            in_zero_child,
  input  logic [31:0]            in_one_child,
  input  logic [63:0]            in_addr_high,
  input  logic [63:0]            in_addr_low,
  output logic [30:0]            out_result_id,
  output logic [7:0]             out_prefix_len
);

  localparam int AW = $clog2(NODE_COUNT);

  // Walk registers.
  logic [31:0]  w_r, w_nxt;
  logic [7:0]   n_r, n_nxt;
  logic [7:0]   limit_r, limit_nxt;
  logic [7:0]   off_r, off_nxt;
  logic [127:0] shift_r, shift_nxt;
  logic         finish_r, finish_nxt;
  logic         use_ram_r, use_ram_nxt;
  logic         bit_r, bit_nxt;
  logic         oob_r, oob_nxt;
  logic [31:0]  v4_root_r, v4_root_nxt;
  logic [30:0]  out_result_id_r, out_result_id_nxt;
  logic [7:0]   out_prefix_len_r, out_prefix_len_nxt;

  logic [31:0]  cur_w;
  logic [63:0]  rdata;
  logic         wr_en;
  logic [31:0]  lo32;
  logic [31:0]  lo_top;

  // Node memory: one child word in the high half, zero child word in the low.
  assign wr_en = cmd.write_node && ({18'd0, in_node_index} < 32'(NODE_COUNT));

  btlpm_ram #(
    .WIDTH (64),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'({18'd0, in_node_index})),
    .wdata ({in_one_child, in_zero_child}),
    .re    (cmd.step),
    .raddr (cur_w[AW-1:0]),
    .rdata (rdata)
  );

  // Current word: the child picked from the last node read, zero when that node index was out of range, or the root.
  always_comb begin
    if (!use_ram_r) begin
      cur_w = w_r;
    end else if (oob_r) begin
      cur_w = '0;
    end else if (bit_r) begin
      cur_w = rdata[63:32];
    end else begin
      cur_w = rdata[31:0];
    end
  end

  assign status.term     = cur_w[btlpm_pkg::TERM_POS];
  assign status.at_limit = (n_r >= limit_r);
  assign status.finish   = finish_r;

  assign lo32   = in_addr_low[31:0];
  assign lo_top = in_addr_low[63:32];

  // Next values of the walk registers.
  always_comb begin
    w_nxt              = w_r;
    n_nxt              = n_r;
    limit_nxt          = limit_r;
    off_nxt            = off_r;
    shift_nxt          = shift_r;
    finish_nxt         = finish_r;
    use_ram_nxt        = use_ram_r;
    bit_nxt            = bit_r;
    oob_nxt            = oob_r;
    v4_root_nxt        = v4_root_r;
    out_result_id_nxt  = out_result_id_r;
    out_prefix_len_nxt = out_prefix_len_r;

    if (cmd.start) begin
      n_nxt       = '0;
      use_ram_nxt = 1'b0;
      finish_nxt  = 1'b0;
      off_nxt     = '0;
      w_nxt       = v4_root_r;
      limit_nxt   = btlpm_pkg::V4_BITS;
      shift_nxt   = {lo32, 96'd0};
      case (btlpm_pkg::kind_t'(in_kind))
        btlpm_pkg::KIND_FINISH: begin
          // Follow zero children from node 0.
          finish_nxt = 1'b1;
          w_nxt      = '0;
          limit_nxt  = btlpm_pkg::FINISH_DEPTH;
          shift_nxt  = '0;
        end
        btlpm_pkg::KIND_LOOKUP_V4: begin
        end
        btlpm_pkg::KIND_LOOKUP_V6: begin
          if (in_addr_high == 64'd0 &&
              (lo_top == btlpm_pkg::V4_MAPPED_TOP || lo_top == btlpm_pkg::SIIT_TOP)) begin
            off_nxt = btlpm_pkg::V4_EMBED_OFFSET;
          end else if (in_addr_high[63:32] == btlpm_pkg::TEREDO_PREFIX) begin
            // Teredo carries the client address inverted.
            off_nxt   = btlpm_pkg::V4_EMBED_OFFSET;
            shift_nxt = {~lo32, 96'd0};
          end else if (in_addr_high[63:48] == btlpm_pkg::SIXTOFOUR_PREFIX) begin
            off_nxt   = btlpm_pkg::SIXTOFOUR_OFFSET;
            shift_nxt = {in_addr_high[47:16], 96'd0};
          end else begin
            // Native address: full walk from node 0.
            w_nxt     = '0;
            limit_nxt = btlpm_pkg::V6_BITS;
            shift_nxt = {in_addr_high, in_addr_low};
          end
        end
        default: begin
        end
      endcase
    end

    // One node read per step; the next address bit picks the child.
    if (cmd.step) begin
      use_ram_nxt = 1'b1;
      bit_nxt     = shift_r[127];
      oob_nxt     = (cur_w >= 32'(NODE_COUNT));
      shift_nxt   = {shift_r[126:0], 1'b0};
      n_nxt       = n_r + 8'd1;
    end

    if (cmd.save_root) begin
      v4_root_nxt = cur_w;
    end

    if (cmd.load_out) begin
      out_result_id_nxt  = cur_w[30:0];
      out_prefix_len_nxt = n_r + off_r;
    end
  end

  // Cached IPv4 root needs its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_root_r <= '0;
    end else begin
      v4_root_r <= v4_root_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    w_r              <= w_nxt;
    n_r              <= n_nxt;
    limit_r          <= limit_nxt;
    off_r            <= off_nxt;
    shift_r          <= shift_nxt;
    finish_r         <= finish_nxt;
    use_ram_r        <= use_ram_nxt;
    bit_r            <= bit_nxt;
    oob_r            <= oob_nxt;
    out_result_id_r  <= out_result_id_nxt;
    out_prefix_len_r <= out_prefix_len_nxt;
  end

  assign out_result_id  = out_result_id_r;
  assign out_prefix_len = out_prefix_len_r;

endmodule

// ----- rtl/binary_trie_ip_prefix_lookup_core.sv -----
`timescale 1ns / 1ps
// A write item goes straight to node memory. A lookup walks one trie node per cycle from the
// node memory's registered read port: up to 32 node reads for IPv4 and 128 for IPv6, and
// holds at the end while the output register is busy. A finish item reads up to 96 nodes.
// One walk at a time; the input stalls meanwhile.
// Reset (synchronous, active low) clears the controller, output valid and the cached IPv4
// root; node memory contents are undefined until written.
// ----------------------------------------------------------------------------
// Binary trie IP prefix lookup core
// Longest prefix match over a binary trie held in node memory, with IPv4
// and IPv4-embedding IPv6 addresses walked from a cached IPv4 root.
// ----------------------------------------------------------------------------
module binary_trie_ip_prefix_lookup_core #(
  parameter int NODE_COUNT = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [13:0] in_node_index,
  input  logic [31:0] in_zero_child,
  input  logic [31:0] in_one_child,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_result_id,
  output logic [7:0]  out_prefix_len
);

  btlpm_pkg::dp_cmd_t    cmd;
  btlpm_pkg::dp_status_t status;

  // Sequencer.
  btlpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Node memory, walk registers and result.
  btlpm_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_kind        (in_kind),
    .in_node_index  (in_node_index),
    .in_zero_child  (in_zero_child),
    .in_one_child   (in_one_child),
    .in_addr_high   (in_addr_high),
    .in_addr_low    (in_addr_low),
    .out_result_id  (out_result_id),
    .out_prefix_len (out_prefix_len)
  );

endmodule

// ----- rtl/btlpm_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary trie lookup port checker
// Watches the core's ports for output channel rules and for the input
// stall behavior around writes and lookups.
// ----------------------------------------------------------------------------
module btlpm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_result_id,
  input logic [7:0]  out_prefix_len
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_id) && $stable(out_prefix_len))
    else $error("result payload changed while stalled");

  // A prefix length never exceeds the address length.
  a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_prefix_len <= 8'd128)
    else $error("prefix length out of range");

  // A walk item moves the controller out of idle, so the input stalls after it.
  a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind != btlpm_pkg::KIND_WRITE |=> in_stall)
    else $error("input not stalled after a walk item");

  // A write item leaves the controller idle, so the input stays ready.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == btlpm_pkg::KIND_WRITE |=> !in_stall)
    else $error("input stalled after a write item");

endmodule

bind binary_trie_ip_prefix_lookup_core btlpm_chk u_btlpm_chk (.*);
